/* design/bxu_pkg.sv */
// shared types and codes for the box transform and union block
// no dependencies
package bxu_pkg;

  // input command codes
  typedef enum logic [1:0] {
    CMD_CHILD_ROW = 2'd0,
    CMD_ROOT_ROW  = 2'd1,
    CMD_BOX       = 2'd2,
    CMD_LAST_BOX  = 2'd3
  } cmd_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CAXIS,
    ST_CEMIT,
    ST_RPREP,
    ST_RAXIS,
    ST_REMIT
  } state_t;

  localparam logic [1:0] ROW_Z = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic       load_box;
    logic       load_row;
    logic       step;
    logic       use_root;
    logic [1:0] axis;
    logic       copy;
    logic       emit_child;
    logic       prep;
    logic       emit_root;
  } ctrl_t;

  // status from datapath to controller
  typedef struct packed {
    logic out_free;
    logic use_tf;
    logic last_box;
    logic root_tf;
  } stat_t;

endpackage

/* design/bxu_ctrl.sv */
// sequencing controller for the box transform and union block
// depends on bxu_pkg
module bxu_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [1:0]     cmd,
  output logic           in_ready,
  input  bxu_pkg::stat_t stat,
  output bxu_pkg::ctrl_t ctrl
);
  import bxu_pkg::*;

  state_t     state, state_next;
  logic [1:0] axis, axis_next;
  logic       accept;

  assign accept = in_valid && in_ready;

  // state and axis counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      axis  <= 2'd0;
    end else begin
      state <= state_next;
      axis  <= axis_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    axis_next  = axis;
    unique case (state)
      ST_IDLE: begin
        axis_next = 2'd0;
        if (accept && (cmd == CMD_BOX || cmd == CMD_LAST_BOX)) state_next = ST_CAXIS;
      end
      ST_CAXIS: begin
        if (!stat.use_tf || axis == ROW_Z) begin
          state_next = ST_CEMIT;
          axis_next  = 2'd0;
        end else axis_next = axis + 2'd1;
      end
      ST_CEMIT: begin
        if (stat.out_free) state_next = stat.last_box ? ST_RPREP : ST_IDLE;
      end
      ST_RPREP: state_next = ST_RAXIS;
      ST_RAXIS: begin
        if (!stat.root_tf || axis == ROW_Z) begin
          state_next = ST_REMIT;
          axis_next  = 2'd0;
        end else axis_next = axis + 2'd1;
      end
      ST_REMIT: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = (state == ST_IDLE);
    ctrl     = '0;
    ctrl.axis = axis;
    unique case (state)
      ST_IDLE: begin
        ctrl.load_box = accept && (cmd == CMD_BOX || cmd == CMD_LAST_BOX);
        ctrl.load_row = accept && (cmd == CMD_CHILD_ROW || cmd == CMD_ROOT_ROW);
      end
      ST_CAXIS: begin
        ctrl.step = stat.use_tf;
        ctrl.copy = !stat.use_tf;
      end
      ST_CEMIT: ctrl.emit_child = stat.out_free;
      ST_RPREP: ctrl.prep = 1'b1;
      ST_RAXIS: begin
        ctrl.use_root = 1'b1;
        ctrl.step     = stat.root_tf;
        ctrl.copy     = !stat.root_tf;
      end
      ST_REMIT: ctrl.emit_root = stat.out_free;
      default: ;
    endcase
  end

endmodule

/* design/bxu_dp.sv */
// datapath: transform storage, shared axis multiply-add unit, union, output register
// depends on bxu_pkg
module bxu_dp #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  bxu_pkg::ctrl_t     ctrl,
  output bxu_pkg::stat_t     stat,
  input  logic               cfg_valid,
  input  logic               cfg_data,
  input  logic [1:0]         cmd,
  input  logic [1:0]         row,
  input  logic signed [31:0] field_a,
  input  logic signed [31:0] field_b,
  input  logic signed [31:0] field_c,
  input  logic signed [31:0] field_d,
  input  logic signed [31:0] field_e,
  input  logic signed [31:0] field_f,
  input  logic               use_transform,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               kind,
  output logic signed [31:0] center_x,
  output logic signed [31:0] center_y,
  output logic signed [31:0] center_z,
  output logic [30:0]        half_x,
  output logic [30:0]        half_y,
  output logic [30:0]        half_z,
  output logic               last
);
  import bxu_pkg::*;

  logic signed [31:0] crot [3][3];
  logic signed [31:0] ctr  [3];
  logic signed [31:0] rrot [3][3];
  logic signed [31:0] rtr  [3];
  logic signed [31:0] umin [3];
  logic signed [31:0] umax [3];
  logic signed [31:0] bc   [3];
  logic [30:0]        bh   [3];
  logic signed [31:0] xc   [3];
  logic [30:0]        xh   [3];
  logic               first_pending;
  logic               root_tf;
  logic               use_tf;
  logic               last_box;

  // config register
  always_ff @(posedge clk) begin
    if (rst) root_tf <= 1'b0;
    else if (cfg_valid) root_tf <= cfg_data;
  end

  // transform rows
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        ctr[i] <= '0;
        rtr[i] <= '0;
        for (int j = 0; j < 3; j++) begin
          crot[i][j] <= '0;
          rrot[i][j] <= '0;
        end
      end
    end else if (ctrl.load_row && row <= ROW_Z) begin
      if (cmd == CMD_CHILD_ROW) begin
        crot[row] <= '{field_a, field_b, field_c};
        ctr[row]  <= field_d;
      end else begin
        rrot[row] <= '{field_a, field_b, field_c};
        rtr[row]  <= field_d;
      end
    end
  end

  // shared axis unit: one output axis per cycle
  logic signed [31:0] rsel [3];
  logic signed [31:0] tsel;
  logic signed [63:0] pc   [3];
  logic [63:0]        ph   [3];
  logic [31:0]        rmag [3];
  logic signed [65:0] acc_c;
  logic [65:0]        acc_h;
  logic signed [31:0] sat_c;
  logic [30:0]        sat_h;

  always_comb begin
    acc_c = '0;
    acc_h = '0;
    tsel  = ctrl.use_root ? rtr[ctrl.axis] : ctr[ctrl.axis];
    acc_c = 66'(tsel);
    for (int j = 0; j < 3; j++) begin
      rsel[j] = ctrl.use_root ? rrot[ctrl.axis][j] : crot[ctrl.axis][j];
      rmag[j] = rsel[j][31] ? (~rsel[j] + 32'd1) : rsel[j];
      pc[j]   = rsel[j] * bc[j];
      ph[j]   = rmag[j] * {1'b0, bh[j]};
      acc_c   = acc_c + 66'(pc[j] >>> FRAC_BITS);
      acc_h   = acc_h + 66'(ph[j] >> FRAC_BITS);
    end
    if (acc_c > 66'sd2147483647) sat_c = 32'sh7fffffff;
    else if (acc_c < -66'sd2147483648) sat_c = 32'sh80000000;
    else sat_c = acc_c[31:0];
    sat_h = (acc_h > 66'd2147483647) ? 31'h7fffffff : acc_h[30:0];
  end

  // child corners and merged box
  logic signed [33:0] lo_w [3];
  logic signed [33:0] hi_w [3];
  logic signed [31:0] lo   [3];
  logic signed [31:0] hi   [3];
  logic signed [32:0] msum [3];
  logic signed [32:0] mdif [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lo_w[i] = 34'(xc[i]) - 34'(signed'({1'b0, xh[i]}));
      hi_w[i] = 34'(xc[i]) + 34'(signed'({1'b0, xh[i]}));
      if (lo_w[i] < -34'sd2147483648) lo[i] = 32'sh80000000;
      else lo[i] = lo_w[i][31:0];
      if (hi_w[i] > 34'sd2147483647) hi[i] = 32'sh7fffffff;
      else hi[i] = hi_w[i][31:0];
      msum[i] = 33'(umin[i]) + 33'(umax[i]);
      mdif[i] = 33'(umax[i]) - 33'(umin[i]);
    end
  end

  // box operands, axis results and union
  always_ff @(posedge clk) begin
    if (ctrl.load_box) begin
      bc[0] <= field_a;
      bc[1] <= field_b;
      bc[2] <= field_c;
      bh[0] <= field_d[31] ? '0 : field_d[30:0];
      bh[1] <= field_e[31] ? '0 : field_e[30:0];
      bh[2] <= field_f[31] ? '0 : field_f[30:0];
      use_tf   <= use_transform;
      last_box <= (cmd == CMD_LAST_BOX);
    end else if (ctrl.prep) begin
      for (int i = 0; i < 3; i++) begin
        bc[i] <= msum[i][32:1];
        bh[i] <= mdif[i][31:1];
      end
    end
    if (ctrl.step) begin
      xc[ctrl.axis] <= sat_c;
      xh[ctrl.axis] <= sat_h;
    end else if (ctrl.copy) begin
      xc <= bc;
      xh <= bh;
    end
    if (ctrl.emit_child) begin
      for (int i = 0; i < 3; i++) begin
        if (first_pending || umin[i] > lo[i]) umin[i] <= lo[i];
        if (first_pending || umax[i] < hi[i]) umax[i] <= hi[i];
      end
    end
  end

  // run tracking
  always_ff @(posedge clk) begin
    if (rst) first_pending <= 1'b1;
    else if (ctrl.emit_root) first_pending <= 1'b1;
    else if (ctrl.emit_child) first_pending <= 1'b0;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (ctrl.emit_child || ctrl.emit_root) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit_child || ctrl.emit_root) begin
      kind     <= ctrl.emit_root;
      last     <= ctrl.emit_root || !last_box;
      center_x <= xc[0];
      center_y <= xc[1];
      center_z <= xc[2];
      half_x   <= xh[0];
      half_y   <= xh[1];
      half_z   <= xh[2];
    end
  end

  assign stat.out_free = !out_valid || out_ready;
  assign stat.use_tf   = use_tf;
  assign stat.last_box = last_box;
  assign stat.root_tf  = root_tf;

endmodule

/* design/box_transform_and_union.sv */
// Box transform and union. Row items (cmd 0/1) load a child or root transform row and give
// no result. A child box steps through accept, one output axis per cycle through the shared
// three-product multiply-add unit (a single copy step without the child transform), and
// emit; a last child then adds merge, the three root axes (or one copy step without the
// root transform) and emit. Results sit in an output register, so a new item is taken
// while the last result still waits. The config write port is always ready.
// depends on bxu_pkg, bxu_ctrl, bxu_dp
module box_transform_and_union #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         cmd,
  input  logic [1:0]         row,
  input  logic signed [31:0] field_a,
  input  logic signed [31:0] field_b,
  input  logic signed [31:0] field_c,
  input  logic signed [31:0] field_d,
  input  logic signed [31:0] field_e,
  input  logic signed [31:0] field_f,
  input  logic               use_transform,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               kind,
  output logic signed [31:0] center_x,
  output logic signed [31:0] center_y,
  output logic signed [31:0] center_z,
  output logic [30:0]        half_x,
  output logic [30:0]        half_y,
  output logic [30:0]        half_z,
  output logic               last
);
  import bxu_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  assign cfg_ready = 1'b1;

  // controller
  bxu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .cmd      (cmd),
    .in_ready (in_ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  // datapath
  bxu_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .stat          (stat),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .row           (row),
    .field_a       (field_a),
    .field_b       (field_b),
    .field_c       (field_c),
    .field_d       (field_d),
    .field_e       (field_e),
    .field_f       (field_f),
    .use_transform (use_transform),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .center_x      (center_x),
    .center_y      (center_y),
    .center_z      (center_z),
    .half_x        (half_x),
    .half_y        (half_y),
    .half_z        (half_z),
    .last          (last)
  );

`ifndef SYNTHESIS
  // root result always closes the run
  a_root_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind |-> last) else $error("root item without last");

  // a box item keeps the input closed for at least the next cycle
  a_box_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && cmd[1] |=> !in_ready) else $error("input open after box");

  // row loads never produce a result
  a_row_quiet: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !cmd[1] && !out_valid |=> !out_valid)
    else $error("result after row item");

  // nothing is shown right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid) else $error("result valid after reset");
`endif

endmodule

/* bench/box_transform_and_union_check.sv */
// result checker for the box transform and union block
// watches the item, config and result channels, predicts and compares; depends on bxu_pkg
`timescale 1ns / 100ps

module box_transform_and_union_check (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic               cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         cmd,
  input  logic [1:0]         row,
  input  logic signed [31:0] field_a,
  input  logic signed [31:0] field_b,
  input  logic signed [31:0] field_c,
  input  logic signed [31:0] field_d,
  input  logic signed [31:0] field_e,
  input  logic signed [31:0] field_f,
  input  logic               use_transform,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               kind,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic signed [31:0] center_z,
  input  logic [30:0]        half_x,
  input  logic [30:0]        half_y,
  input  logic [30:0]        half_z,
  input  logic               last,
  output int                 fail_count,
  output int                 pending_count
);
  import bxu_pkg::*;

  localparam int FRAC = 16;

  typedef struct packed {
    logic        kind;
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] cz;
    logic [30:0] hx;
    logic [30:0] hy;
    logic [30:0] hz;
    logic        last;
  } bounds_t;

  longint  child_rot [9];
  longint  child_tr [3];
  longint  root_rot [9];
  longint  root_tr [3];
  longint  umin [3];
  longint  umax [3];
  bit      first_box;
  bit      root_tf;
  bounds_t expected_bounds [$];

  assign pending_count = expected_bounds.size();

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint sat_half(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < 0) return 0;
    return v;
  endfunction

  // r*c + t and |r|*h per axis, products floored by the fraction shift
  task automatic transform_box(input longint rot [9], input longint tr [3],
                               input longint c [3], input longint h [3],
                               output longint oc [3], output longint oh [3]);
    longint ac, ah, r;
    for (int i = 0; i < 3; i++) begin
      ac = tr[i];
      ah = 0;
      for (int j = 0; j < 3; j++) begin
        r = rot[i*3+j];
        ac += (r * c[j]) >>> FRAC;
        ah += ((r < 0 ? -r : r) * h[j]) >>> FRAC;
      end
      oc[i] = sat32(ac);
      oh[i] = sat_half(ah);
    end
  endtask

  function automatic bounds_t pack_bounds(logic k, longint c [3], longint h [3], logic l);
    bounds_t b;
    b.kind = k;
    b.cx = c[0][31:0];
    b.cy = c[1][31:0];
    b.cz = c[2][31:0];
    b.hx = h[0][30:0];
    b.hy = h[1][30:0];
    b.hz = h[2][30:0];
    b.last = l;
    return b;
  endfunction

  // predict the results of one accepted item
  task automatic predict_item();
    longint c [3], h [3], cc [3], ch [3], mc [3], mh [3], rc [3], rh [3];
    longint lo, hi;
    if (cmd == CMD_CHILD_ROW || cmd == CMD_ROOT_ROW) begin
      if (row <= ROW_Z) begin
        if (cmd == CMD_CHILD_ROW) begin
          child_rot[row*3] = field_a;
          child_rot[row*3+1] = field_b;
          child_rot[row*3+2] = field_c;
          child_tr[row] = field_d;
        end else begin
          root_rot[row*3] = field_a;
          root_rot[row*3+1] = field_b;
          root_rot[row*3+2] = field_c;
          root_tr[row] = field_d;
        end
      end
    end else begin
      c[0] = field_a; c[1] = field_b; c[2] = field_c;
      h[0] = field_d; h[1] = field_e; h[2] = field_f;
      for (int i = 0; i < 3; i++) if (h[i] < 0) h[i] = 0;
      if (use_transform) transform_box(child_rot, child_tr, c, h, cc, ch);
      else begin
        cc = c;
        ch = h;
      end
      for (int i = 0; i < 3; i++) begin
        lo = sat32(cc[i] - ch[i]);
        hi = sat32(cc[i] + ch[i]);
        if (first_box) begin
          umin[i] = lo;
          umax[i] = hi;
        end else begin
          if (umin[i] > lo) umin[i] = lo;
          if (umax[i] < hi) umax[i] = hi;
        end
      end
      first_box = 0;
      if (cmd == CMD_BOX) begin
        expected_bounds.push_back(pack_bounds(1'b0, cc, ch, 1'b1));
      end else begin
        expected_bounds.push_back(pack_bounds(1'b0, cc, ch, 1'b0));
        for (int i = 0; i < 3; i++) begin
          mc[i] = (umin[i] + umax[i]) >>> 1;
          mh[i] = (umax[i] - umin[i]) >>> 1;
        end
        if (root_tf) transform_box(root_rot, root_tr, mc, mh, rc, rh);
        else begin
          rc = mc;
          for (int i = 0; i < 3; i++) rh[i] = sat_half(mh[i]);
        end
        expected_bounds.push_back(pack_bounds(1'b1, rc, rh, 1'b1));
        first_box = 1;
      end
    end
  endtask

  // sample all channels at the rising edge
  always @(posedge clk) begin
    bounds_t got, want;
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        child_rot[i] = 0;
        root_rot[i] = 0;
      end
      for (int i = 0; i < 3; i++) begin
        child_tr[i] = 0;
        root_tr[i] = 0;
        umin[i] = 0;
        umax[i] = 0;
      end
      first_box = 1;
      root_tf = 0;
      fail_count = 0;
      expected_bounds.delete();
    end else begin
      if (cfg_valid && cfg_ready) root_tf = cfg_data;
      if (out_valid && out_ready) begin
        got = '{kind, center_x, center_y, center_z, half_x, half_y, half_z, last};
        if (expected_bounds.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %h", got);
        end else begin
          want = expected_bounds.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch: expected k%0d c(%0d %0d %0d) h(%0d %0d %0d) l%0d",
                       want.kind, $signed(want.cx), $signed(want.cy), $signed(want.cz),
                       want.hx, want.hy, want.hz, want.last);
              $display("          got k%0d c(%0d %0d %0d) h(%0d %0d %0d) l%0d",
                       got.kind, $signed(got.cx), $signed(got.cy), $signed(got.cz),
                       got.hx, got.hy, got.hz, got.last);
            end
          end
        end
      end
      if (in_valid && in_ready) predict_item();
    end
  end

endmodule

/* bench/box_transform_and_union_test.sv */
// stimulus and verdict for the box transform and union block
// depends on bxu_pkg, box_transform_and_union and box_transform_and_union_check
`timescale 1ns / 100ps

module box_transform_and_union_test;
  import bxu_pkg::*;

  logic               clk = 0;
  logic               rst = 1;
  logic               cfg_valid = 0;
  logic               cfg_ready;
  logic               cfg_data = 0;
  logic               in_valid = 0;
  logic               in_ready;
  logic [1:0]         cmd = CMD_CHILD_ROW;
  logic [1:0]         row = 0;
  logic signed [31:0] field_a = 0, field_b = 0, field_c = 0;
  logic signed [31:0] field_d = 0, field_e = 0, field_f = 0;
  logic               use_transform = 0;
  logic               out_valid;
  logic               out_ready = 0;
  logic               kind, last;
  logic signed [31:0] center_x, center_y, center_z;
  logic [30:0]        half_x, half_y, half_z;
  int                 fail_count, pending_count;
  bit                 hold_done = 0;

  box_transform_and_union dut (.*);
  box_transform_and_union_check checker_i (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // field value with extremes favored
  function automatic logic [31:0] pick_value(bit box_coord);
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom();
      3: return $urandom_range(0, 1) ? 32'h00010000 : 32'hffff0000;
      default: return box_coord ? {{12{1'b0}}, 20'($urandom())} - 32'h00080000
                                : {{14{1'b0}}, 18'($urandom())} - 32'h00020000;
    endcase
  endfunction

  task automatic send_item(logic [1:0] c, logic [1:0] r, logic [31:0] a, logic [31:0] b,
                           logic [31:0] cc, logic [31:0] d, logic [31:0] e,
                           logic [31:0] f, logic u);
    int gap;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) @(negedge clk);
    cmd <= c; row <= r; field_a <= a; field_b <= b; field_c <= cc;
    field_d <= d; field_e <= e; field_f <= f; use_transform <= u;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid <= 0;
  endtask

  task automatic send_row(logic [1:0] c, logic [1:0] r);
    send_item(c, r, pick_value(0), pick_value(0), pick_value(0), pick_value(1),
              $urandom(), $urandom(), 1'($urandom_range(0, 1)));
  endtask

  task automatic send_box(logic [1:0] c);
    send_item(c, 2'($urandom_range(0, 3)), pick_value(1), pick_value(1), pick_value(1),
              pick_value(1), pick_value(1), pick_value(1), 1'($urandom_range(0, 1)));
  endtask

  task automatic write_flag(logic v);
    while (pending_count != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_data <= v;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // receiver: random stalls, one long hold early on
  initial begin
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    repeat (40) @(negedge clk);
    out_ready <= 0;
    repeat (300) @(negedge clk);
    hold_done = 1;
    forever begin
      gap = $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0) gap = 0;
      out_ready <= 0;
      repeat (gap) @(negedge clk);
      out_ready <= 1;
      @(negedge clk);
    end
  end

  initial begin
    int n;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed: rows incl. ignored index three, single box, lone last box, extremes
    for (int r = 0; r < 4; r++) send_row(CMD_CHILD_ROW, 2'(r));
    for (int r = 0; r < 4; r++) send_row(CMD_ROOT_ROW, 2'(r));
    send_item(CMD_BOX, 0, 32'h7fffffff, 32'h80000000, 0, 32'h7fffffff, 32'h80000000,
              32'hffffffff, 0);
    send_item(CMD_LAST_BOX, 0, 32'h80000000, 32'h7fffffff, 32'h00010000, 32'h7fffffff,
              32'h7fffffff, 0, 1);
    send_item(CMD_LAST_BOX, 3, 32'hffffffff, 0, 32'h7fffffff, 1, 32'h80000000, 5, 1);
    send_item(CMD_CHILD_ROW, 0, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
              0, 0, 0);
    send_item(CMD_BOX, 1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
              32'h7fffffff, 32'h7fffffff, 1);
    send_box(CMD_LAST_BOX);
    for (int phase = 0; phase < 4; phase++) begin
      write_flag(phase == 0 || phase == 2);
      n = 0;
      while (n < 255) begin
        case ($urandom_range(0, 7))
          0: begin
            for (int r = 0; r < 3; r++) send_row(CMD_CHILD_ROW, 2'(r));
            n += 3;
          end
          1: begin
            for (int r = 0; r < 3; r++) send_row(CMD_ROOT_ROW, 2'(r));
            n += 3;
          end
          2: begin
            send_row(2'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
            n++;
          end
          default: begin
            int k;
            k = $urandom_range(0, 5);
            repeat (k) send_box(CMD_BOX);
            send_box(CMD_LAST_BOX);
            n += k + 1;
          end
        endcase
      end
    end
    while (pending_count != 0 || !hold_done) @(negedge clk);
    repeat (30) @(negedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

endmodule
